/* rtl/twc_pkg.sv */
// ----------------------------------------------------------------------------
// twc_pkg
// Shared types, constants and address helpers for the text window console.
// ----------------------------------------------------------------------------
package twc_pkg;

    // Screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int NUM_CELLS   = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(NUM_CELLS);

    // Field widths
    localparam int OP_W   = 2;
    localparam int CODE_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int WORD_W = 16;

    // Screen coordinate widths: window origin plus cursor or walk offset
    localparam int SCOL_W = COL_W + 1;
    localparam int SROW_W = ROW_W + 1;

    // Cell contents
    localparam logic [CODE_W-1:0] CELL_ATTR  = 8'h0F;
    localparam logic [CODE_W-1:0] BLANK_CODE = 8'h20;
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT_CHAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_CELL = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_WIN = 2'd2;

    // Configuration register map (index = paddr[4:2])
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_WIN_LEFT     = 3'd0;
    localparam logic [2:0] REG_WIN_TOP      = 3'd1;
    localparam logic [2:0] REG_WIN_WIDTH    = 3'd2;
    localparam logic [2:0] REG_WIN_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_CURSOR_GLYPH = 3'd4;

    // Register reset values
    localparam logic [COL_W-1:0]  WIN_LEFT_RST     = 7'd0;
    localparam logic [ROW_W-1:0]  WIN_TOP_RST      = 5'd0;
    localparam logic [COL_W-1:0]  WIN_WIDTH_RST    = 7'd80;
    localparam logic [ROW_W-1:0]  WIN_HEIGHT_RST   = 5'd25;
    localparam logic [CODE_W-1:0] CURSOR_GLYPH_RST = 8'd32;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CODE_W-1:0] char_code;
        logic [COL_W-1:0]  read_col;
        logic [ROW_W-1:0]  read_row;
    } request_t;

    typedef struct packed {
        logic [WORD_W-1:0] cell_word;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
    } result_t;

    function automatic logic [WORD_W-1:0] make_cell(input logic [CODE_W-1:0] code);
        return {CELL_ATTR, code};
    endfunction

    function automatic logic in_screen(input logic [SCOL_W-1:0] col,
                                       input logic [SROW_W-1:0] row);
        return (int'(col) < SCREEN_COLS) && (int'(row) < SCREEN_ROWS);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [SCOL_W-1:0] col,
                                                    input logic [SROW_W-1:0] row);
        int lin;
        lin = int'(row) * SCREEN_COLS + int'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/text_window_console.sv */
// ----------------------------------------------------------------------------
// text_window_console
// Text screen of attribute/character cells with a cursor inside a window.
// ----------------------------------------------------------------------------
// Sequence: a put character without scroll and unused codes finish in S_EXEC; a read cell
//   passes S_EXEC and S_RDATA; a scroll walks S_SCROLL and S_BLANK, a clear walks S_CLEAR.
// Requests are taken only while busy is low; window walks move one cell a cycle through
//   the single write port of the screen memory.
// Reset: a blanking pass writes all SCREEN_COLS * SCREEN_ROWS cells with busy high;
//   register writes are taken meanwhile. The receiver cannot stall done.
module text_window_console (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  twc_pkg::request_t                 request,
    // result channel
    output logic                              done,
    output twc_pkg::result_t                  result,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [twc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import twc_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_INIT   = 3'd0;  // blanking pass after reset
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;  // decode and single-cell work
    localparam logic [2:0] S_RDATA  = 3'd3;  // read data back from memory
    localparam logic [2:0] S_SCROLL = 3'd4;  // copy rows up one
    localparam logic [2:0] S_BLANK  = 3'd5;  // blank last row, draw glyph
    localparam logic [2:0] S_CLEAR  = 3'd6;  // blank whole window

    // ------------------------------------------------------------------
    // Screen memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] screen_mem [NUM_CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= screen_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [2:0]        state_reg,     state_next;
    logic [ADDR_W-1:0] init_addr_reg, init_addr_next;
    request_t          req_reg,       req_next;
    logic [COL_W-1:0]  cur_x_reg,     cur_x_next;
    logic [ROW_W-1:0]  cur_y_reg,     cur_y_next;
    logic [COL_W-1:0]  col_cnt_reg,   col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg,   row_cnt_next;

    // Write stage for window walks: scroll data arrives in the cycle after its read
    logic              pend_we_reg,       pend_we_next;
    logic [ADDR_W-1:0] pend_addr_reg,     pend_addr_next;
    logic              pend_from_mem_reg, pend_from_mem_next;
    logic              pend_src_ok_reg,   pend_src_ok_next;
    logic [WORD_W-1:0] pend_data_reg,     pend_data_next;

    logic              done_reg,   done_next;
    result_t           result_reg, result_next;

    // Configuration registers
    logic [COL_W-1:0]  win_left_reg;
    logic [ROW_W-1:0]  win_top_reg;
    logic [COL_W-1:0]  win_width_reg;
    logic [ROW_W-1:0]  win_height_reg;
    logic [CODE_W-1:0] glyph_reg;

    // ------------------------------------------------------------------
    // Configuration port: zero-wait writes and reads
    // ------------------------------------------------------------------
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= WIN_LEFT_RST;
            win_top_reg    <= WIN_TOP_RST;
            win_width_reg  <= WIN_WIDTH_RST;
            win_height_reg <= WIN_HEIGHT_RST;
            glyph_reg      <= CURSOR_GLYPH_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_WIN_LEFT:     win_left_reg   <= pwdata[COL_W-1:0];
                REG_WIN_TOP:      win_top_reg    <= pwdata[ROW_W-1:0];
                REG_WIN_WIDTH:    win_width_reg  <= pwdata[COL_W-1:0];
                REG_WIN_HEIGHT:   win_height_reg <= pwdata[ROW_W-1:0];
                REG_CURSOR_GLYPH: glyph_reg      <= pwdata[CODE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_WIN_LEFT:     prdata = 32'(win_left_reg);
            REG_WIN_TOP:      prdata = 32'(win_top_reg);
            REG_WIN_WIDTH:    prdata = 32'(win_width_reg);
            REG_WIN_HEIGHT:   prdata = 32'(win_height_reg);
            REG_CURSOR_GLYPH: prdata = 32'(glyph_reg);
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Window geometry; a zero width or height counts as one
    // ------------------------------------------------------------------
    logic [COL_W-1:0] eff_w, w_last;
    logic [ROW_W-1:0] eff_h, h_last;

    assign eff_w  = (win_width_reg == '0)  ? COL_W'(1) : win_width_reg;
    assign eff_h  = (win_height_reg == '0) ? ROW_W'(1) : win_height_reg;
    assign w_last = eff_w - COL_W'(1);
    assign h_last = eff_h - ROW_W'(1);

    // Cursor cell on the screen
    logic [SCOL_W-1:0] cur_scol;
    logic [SROW_W-1:0] cur_srow;

    assign cur_scol = SCOL_W'(win_left_reg) + SCOL_W'(cur_x_reg);
    assign cur_srow = SROW_W'(win_top_reg)  + SROW_W'(cur_y_reg);

    // Walk position: destination row and the row below it (scroll source)
    logic [ROW_W-1:0]  walk_r;
    logic [SCOL_W-1:0] walk_scol;
    logic [SROW_W-1:0] walk_drow, walk_srow;

    assign walk_r    = (state_reg == S_BLANK) ? h_last : row_cnt_reg;
    assign walk_scol = SCOL_W'(win_left_reg) + SCOL_W'(col_cnt_reg);
    assign walk_drow = SROW_W'(win_top_reg)  + SROW_W'(walk_r);
    assign walk_srow = walk_drow + SROW_W'(1);

    // ------------------------------------------------------------------
    // Put character: new cursor position
    // ------------------------------------------------------------------
    logic              is_newline, is_backspace;
    logic [WORD_W-1:0] put_data;
    logic [COL_W-1:0]  adv_x, new_x;
    logic [ROW_W-1:0]  new_y;
    logic              need_scroll;

    assign is_newline   = (req_reg.char_code == CODE_LF) || (req_reg.char_code == CODE_CR);
    assign is_backspace = (req_reg.char_code == CODE_BS);
    assign put_data     = make_cell((is_newline || is_backspace) ? BLANK_CODE
                                                                 : req_reg.char_code);
    assign adv_x        = cur_x_reg + COL_W'(1);

    always_comb
    begin
        new_x = cur_x_reg;
        new_y = cur_y_reg;
        if (is_newline)
        begin
            new_x = '0;
            new_y = cur_y_reg + ROW_W'(1);
        end
        else if (is_backspace)
        begin
            if (cur_x_reg != '0)
            begin
                new_x = cur_x_reg - COL_W'(1);
            end
            else if (cur_y_reg != '0)
            begin
                new_x = w_last;
                new_y = cur_y_reg - ROW_W'(1);
            end
        end
        else if ((adv_x >= eff_w) || (adv_x == '0))
        begin
            // wrap at the right edge, also from a column past a shrunk window
            new_x = '0;
            new_y = cur_y_reg + ROW_W'(1);
        end
        else
        begin
            new_x = adv_x;
        end
    end

    assign need_scroll = (new_y >= eff_h);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        init_addr_next     = init_addr_reg;
        req_next           = req_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        col_cnt_next       = col_cnt_reg;
        row_cnt_next       = row_cnt_reg;
        pend_we_next       = 1'b0;
        pend_addr_next     = pend_addr_reg;
        pend_from_mem_next = pend_from_mem_reg;
        pend_src_ok_next   = pend_src_ok_reg;
        pend_data_next     = pend_data_reg;
        done_next          = 1'b0;
        result_next        = result_reg;

        // Drain the walk write stage; it never meets a direct write below
        mem_we    = pend_we_reg;
        mem_waddr = pend_addr_reg;
        mem_wdata = pend_from_mem_reg ? (pend_src_ok_reg ? mem_rdata_reg : '0)
                                      : pend_data_reg;
        mem_raddr = cell_addr(walk_scol, walk_srow);

        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_addr_reg;
                mem_wdata = make_cell(BLANK_CODE);
                if (init_addr_reg == ADDR_W'(NUM_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_addr_next = init_addr_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                col_cnt_next = '0;
                row_cnt_next = '0;
                case (req_reg.operation)
                    OP_PUT_CHAR:
                    begin
                        // blank or character at the old cursor in one write
                        mem_we    = in_screen(cur_scol, cur_srow);
                        mem_waddr = cell_addr(cur_scol, cur_srow);
                        mem_wdata = put_data;
                        if (need_scroll)
                        begin
                            cur_x_next = '0;
                            cur_y_next = h_last;
                            state_next = (eff_h == ROW_W'(1)) ? S_BLANK : S_SCROLL;
                        end
                        else
                        begin
                            cur_x_next  = new_x;
                            cur_y_next  = new_y;
                            done_next   = 1'b1;
                            result_next = '{cell_word: '0, cursor_col: new_x,
                                            cursor_row: new_y, scrolled: 1'b0};
                            state_next  = S_IDLE;
                        end
                    end
                    OP_READ_CELL:
                    begin
                        mem_raddr  = cell_addr(SCOL_W'(req_reg.read_col),
                                               SROW_W'(req_reg.read_row));
                        state_next = S_RDATA;
                    end
                    OP_CLEAR_WIN:
                    begin
                        cur_x_next = '0;
                        cur_y_next = '0;
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        result_next = '{cell_word: '0, cursor_col: cur_x_reg,
                                        cursor_row: cur_y_reg, scrolled: 1'b0};
                        state_next  = S_IDLE;
                    end
                endcase
            end

            S_RDATA:
            begin
                done_next   = 1'b1;
                result_next = '{cell_word: in_screen(SCOL_W'(req_reg.read_col),
                                                     SROW_W'(req_reg.read_row))
                                           ? mem_rdata_reg : '0,
                                cursor_col: cur_x_reg, cursor_row: cur_y_reg,
                                scrolled: 1'b0};
                state_next  = S_IDLE;
            end

            S_SCROLL:
            begin
                // read the cell below now, write it one row up next cycle
                pend_we_next       = in_screen(walk_scol, walk_drow);
                pend_addr_next     = cell_addr(walk_scol, walk_drow);
                pend_from_mem_next = 1'b1;
                pend_src_ok_next   = in_screen(walk_scol, walk_srow);
                if (col_cnt_reg == w_last)
                begin
                    col_cnt_next = '0;
                    if (row_cnt_reg == h_last - ROW_W'(1))
                    begin
                        state_next = S_BLANK;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + COL_W'(1);
                end
            end

            S_BLANK:
            begin
                // the first column of the last row takes the cursor glyph
                pend_we_next       = in_screen(walk_scol, walk_drow);
                pend_addr_next     = cell_addr(walk_scol, walk_drow);
                pend_from_mem_next = 1'b0;
                pend_data_next     = make_cell((col_cnt_reg == '0) ? glyph_reg : BLANK_CODE);
                if (col_cnt_reg == w_last)
                begin
                    done_next   = 1'b1;
                    result_next = '{cell_word: '0, cursor_col: cur_x_reg,
                                    cursor_row: cur_y_reg, scrolled: 1'b1};
                    state_next  = S_IDLE;
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + COL_W'(1);
                end
            end

            S_CLEAR:
            begin
                // the home cell takes the cursor glyph
                pend_we_next       = in_screen(walk_scol, walk_drow);
                pend_addr_next     = cell_addr(walk_scol, walk_drow);
                pend_from_mem_next = 1'b0;
                pend_data_next     = make_cell(((col_cnt_reg == '0) && (row_cnt_reg == '0))
                                               ? glyph_reg : BLANK_CODE);
                if (col_cnt_reg == w_last)
                begin
                    col_cnt_next = '0;
                    if (row_cnt_reg == h_last)
                    begin
                        done_next   = 1'b1;
                        result_next = '{cell_word: '0, cursor_col: cur_x_reg,
                                        cursor_row: cur_y_reg, scrolled: 1'b0};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + COL_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_addr_reg <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            pend_we_reg   <= 1'b0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            pend_we_reg   <= pend_we_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg           <= req_next;
        pend_addr_reg     <= pend_addr_next;
        pend_from_mem_reg <= pend_from_mem_next;
        pend_src_ok_reg   <= pend_src_ok_next;
        pend_data_reg     <= pend_data_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/twc_checker.sv */
// ----------------------------------------------------------------------------
// twc_checker
// Port-level timing checks for the text window console, bound to the top.
// ----------------------------------------------------------------------------
module twc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input twc_pkg::result_t result
);
    import twc_pkg::*;

    // A result never shows while the block still works on a request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // No result comes in the cycle right after an accept
    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too early after accept");

    // A scroll leaves the cursor in the first column
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (result.cursor_col == '0))
        else $error("scroll left cursor off the first column");

    // Only reads return a cell word, and reads never scroll
    a_word_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.cell_word != '0)) |-> !result.scrolled)
        else $error("cell word and scroll in one result");

endmodule

bind text_window_console twc_checker u_twc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
